// File: rtl/dpb_pkg.sv
// Shared types, constants and register codes of the depth pixel back-projection block.
`timescale 1ns / 1ps

package dpb_pkg;

   // Default coordinate width of column and row.
   localparam int COORD_BITS_DEFAULT = 12;

   // Fixed field widths.
   localparam int DEPTH_BITS  = 16;
   localparam int SCALE_BITS  = 32;
   localparam int CENTER_BITS = 13;
   localparam int INV_BITS    = 24;
   localparam int Z_BITS      = 24;
   localparam int POINT_BITS  = 32;
   localparam int COLOR_BITS  = 8;

   // Configuration channel widths.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // Rounding shifts of the fixed-point products.
   localparam int Z_SHIFT  = 16;
   localparam int XY_SHIFT = 25;

   // Register reset values.
   localparam logic [SCALE_BITS-1:0]         INV_DEPTH_SCALE_RESET = 32'd858993;
   localparam logic [CENTER_BITS-1:0]        CENTER_X_RESET        = 13'd639;
   localparam logic [CENTER_BITS-1:0]        CENTER_Y_RESET        = 13'd479;
   localparam logic signed [INV_BITS-1:0]    INV_FOCAL_X_RESET     = 24'sd34865;
   localparam logic signed [INV_BITS-1:0]    INV_FOCAL_Y_RESET     = -24'sd34953;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_INV_DEPTH_SCALE = 3'd0,
      REG_CENTER_X        = 3'd1,
      REG_CENTER_Y        = 3'd2,
      REG_INV_FOCAL_X     = 3'd3,
      REG_INV_FOCAL_Y     = 3'd4
   } dpb_reg_index_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic [SCALE_BITS-1:0]      inv_depth_scale;
      logic [CENTER_BITS-1:0]     center_x_halves;
      logic [CENTER_BITS-1:0]     center_y_halves;
      logic signed [INV_BITS-1:0] inv_focal_x;
      logic signed [INV_BITS-1:0] inv_focal_y;
   } dpb_cfg_type;

   // Load enables of the five pipeline stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } dpb_stage_en_type;

   // Colour bytes carried alongside the arithmetic.
   typedef struct packed {
      logic [COLOR_BITS-1:0] blue;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] red;
   } dpb_color_type;

endpackage

// File: rtl/dpb_pixel_if.sv
// Request channel carrying one depth pixel.
`timescale 1ns / 1ps

interface dpb_pixel_if #(
   parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEFAULT
);
   logic                              valid;
   logic                              ready;
   logic [COORD_BITS-1:0]             column;
   logic [COORD_BITS-1:0]             row;
   logic [dpb_pkg::DEPTH_BITS-1:0]    depth;
   logic [dpb_pkg::COLOR_BITS-1:0]    blue;
   logic [dpb_pkg::COLOR_BITS-1:0]    green;
   logic [dpb_pkg::COLOR_BITS-1:0]    red;

   modport source (output valid, column, row, depth, blue, green, red, input ready);
   modport sink   (input valid, column, row, depth, blue, green, red, output ready);
endinterface

// File: rtl/dpb_point_if.sv
// Response channel carrying one 3-D point with its colour.
`timescale 1ns / 1ps

interface dpb_point_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dpb_pkg::POINT_BITS-1:0] point_x;
   logic signed [dpb_pkg::POINT_BITS-1:0] point_y;
   logic [dpb_pkg::Z_BITS-1:0]            point_z;
   logic [dpb_pkg::COLOR_BITS-1:0]        out_blue;
   logic [dpb_pkg::COLOR_BITS-1:0]        out_green;
   logic [dpb_pkg::COLOR_BITS-1:0]        out_red;

   modport source (output valid, point_x, point_y, point_z, out_blue, out_green, out_red,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, out_blue, out_green, out_red,
                   output ready);
endinterface

// File: rtl/dpb_csr_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface dpb_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [dpb_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [dpb_pkg::CSR_DATA_BITS-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dpb_csr_regs.sv
// Configuration register file of the back-projection block.
`timescale 1ns / 1ps

module dpb_csr_regs (
   input  logic                 clock,
   input  logic                 reset,
   dpb_csr_if.sink              csr_write,
   output dpb_pkg::dpb_cfg_type cfg
);

   dpb_pkg::dpb_cfg_type cfg_ff;
   dpb_pkg::dpb_cfg_type cfg_in;

   // Writes are always taken; unknown indexes leave the registers alone.
   assign csr_write.ready = 1'b1;

   // Next register contents; only the low bits of the data that fit are kept.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write.valid) begin
         unique case (csr_write.index)
            dpb_pkg::REG_INV_DEPTH_SCALE: begin
               cfg_in.inv_depth_scale = csr_write.data[dpb_pkg::SCALE_BITS-1:0];
            end
            dpb_pkg::REG_CENTER_X: begin
               cfg_in.center_x_halves = csr_write.data[dpb_pkg::CENTER_BITS-1:0];
            end
            dpb_pkg::REG_CENTER_Y: begin
               cfg_in.center_y_halves = csr_write.data[dpb_pkg::CENTER_BITS-1:0];
            end
            dpb_pkg::REG_INV_FOCAL_X: begin
               cfg_in.inv_focal_x = $signed(csr_write.data[dpb_pkg::INV_BITS-1:0]);
            end
            dpb_pkg::REG_INV_FOCAL_Y: begin
               cfg_in.inv_focal_y = $signed(csr_write.data[dpb_pkg::INV_BITS-1:0]);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_depth_scale <= dpb_pkg::INV_DEPTH_SCALE_RESET;
         cfg_ff.center_x_halves <= dpb_pkg::CENTER_X_RESET;
         cfg_ff.center_y_halves <= dpb_pkg::CENTER_Y_RESET;
         cfg_ff.inv_focal_x     <= dpb_pkg::INV_FOCAL_X_RESET;
         cfg_ff.inv_focal_y     <= dpb_pkg::INV_FOCAL_Y_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/dpb_axis_lane.sv
// One lateral axis: offset from the center, scaled by depth and inverse focal length.
`timescale 1ns / 1ps

module dpb_axis_lane #(
   parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  dpb_pkg::dpb_stage_en_type             en,
   input  logic [COORD_BITS-1:0]                 coord,
   input  logic [dpb_pkg::CENTER_BITS-1:0]       center,
   input  logic signed [dpb_pkg::INV_BITS-1:0]   inv,
   input  logic [dpb_pkg::Z_BITS-1:0]            z,
   output logic signed [dpb_pkg::POINT_BITS-1:0] point
);

   // Offset magnitude, product and partial-product widths.
   localparam int MAG_W = (COORD_BITS + 1 > dpb_pkg::CENTER_BITS) ?
                          COORD_BITS + 1 : dpb_pkg::CENTER_BITS;
   localparam int DX_W  = MAG_W + 1;
   localparam int AB_W  = MAG_W + dpb_pkg::INV_BITS;
   localparam int LO_W  = AB_W / 2;
   localparam int HI_W  = AB_W - LO_W;
   localparam int SUM_W = AB_W + dpb_pkg::Z_BITS + 1;
   localparam int SH_W  = SUM_W - dpb_pkg::XY_SHIFT;
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (dpb_pkg::XY_SHIFT - 1);
   localparam logic [SH_W-1:0]  POS_LIMIT  = SH_W'(33'h0_7FFF_FFFF);
   localparam logic [SH_W-1:0]  NEG_LIMIT  = SH_W'(33'h0_8000_0000);

   logic signed [DX_W-1:0]              dx_ff, dx_in;
   logic [MAG_W-1:0]                    abs_dx;
   logic [dpb_pkg::INV_BITS-1:0]        abs_inv;
   logic [AB_W-1:0]                     ab_ff, ab_in;
   logic                                neg2_ff, neg2_in;
   logic [LO_W+dpb_pkg::Z_BITS-1:0]     lo_ff, lo_in;
   logic [HI_W+dpb_pkg::Z_BITS-1:0]     hi_ff, hi_in;
   logic                                neg3_ff;
   logic [SUM_W-1:0]                    sum_ff, sum_in;
   logic                                neg4_ff;
   logic [SH_W-1:0]                     shifted;
   logic [SH_W-1:0]                     limit;
   logic [dpb_pkg::POINT_BITS-1:0]      mag32;
   logic signed [dpb_pkg::POINT_BITS-1:0] point_ff, point_in;

   // Stage 1: signed offset from the principal point, in half pixels.
   always_comb begin
      dx_in = DX_W'({coord, 1'b0}) - DX_W'(center);
   end

   // Stage 2: magnitudes, sign of the result and offset times inverse focal length.
   always_comb begin
      abs_dx  = dx_ff[DX_W-1] ? MAG_W'(-dx_ff) : MAG_W'(dx_ff);
      abs_inv = inv[dpb_pkg::INV_BITS-1] ? dpb_pkg::INV_BITS'(-inv) :
                                           dpb_pkg::INV_BITS'(inv);
      ab_in   = AB_W'(abs_dx) * AB_W'(abs_inv);
      neg2_in = dx_ff[DX_W-1] ^ inv[dpb_pkg::INV_BITS-1];
   end

   // Stage 3: two partial products of the wide magnitude with z.
   always_comb begin
      lo_in = (LO_W+dpb_pkg::Z_BITS)'(ab_ff[LO_W-1:0]) * (LO_W+dpb_pkg::Z_BITS)'(z);
      hi_in = (HI_W+dpb_pkg::Z_BITS)'(ab_ff[AB_W-1:LO_W]) * (HI_W+dpb_pkg::Z_BITS)'(z);
   end

   // Stage 4: recombine the partial products and add the rounding half.
   always_comb begin
      sum_in = SUM_W'(lo_ff) + (SUM_W'(hi_ff) << LO_W) + ROUND_HALF;
   end

   // Stage 5: drop the fraction, saturate and apply the sign.
   always_comb begin
      shifted  = sum_ff[SUM_W-1:dpb_pkg::XY_SHIFT];
      limit    = neg4_ff ? NEG_LIMIT : POS_LIMIT;
      mag32    = (shifted > limit) ? limit[dpb_pkg::POINT_BITS-1:0] :
                                     shifted[dpb_pkg::POINT_BITS-1:0];
      point_in = neg4_ff ? $signed(-mag32) : $signed(mag32);
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         dx_ff <= dx_in;
      end
      if (en.s2) begin
         ab_ff   <= ab_in;
         neg2_ff <= neg2_in;
      end
      if (en.s3) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         neg3_ff <= neg2_ff;
      end
      if (en.s4) begin
         sum_ff  <= sum_in;
         neg4_ff <= neg3_ff;
      end
      if (en.s5) begin
         point_ff <= point_in;
      end
   end

   assign point = point_ff;

endmodule

// File: rtl/depth_pixel_backprojection_core.sv
// Top level of the depth pixel back-projection block.
// Pipeline: five register stages; a request accepted into stage 1 moves through stages 2
// to 4, and its point is presented from the stage 5 registers.
// Throughput: one request per cycle while no response stall holds the five-stage multiply pipeline.
// A stalled response holds the pipeline; empty stages still fill up behind it.
// Reset (synchronous, active high) empties all stages and loads the register defaults.
`timescale 1ns / 1ps

module depth_pixel_backprojection_core #(
   parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   dpb_pixel_if.sink    req_pixel,
   dpb_point_if.source  rsp_point,
   dpb_csr_if.sink      csr_write
);

   localparam int ZP_W = dpb_pkg::DEPTH_BITS + dpb_pkg::SCALE_BITS;
   localparam int ZS_W = ZP_W - dpb_pkg::Z_SHIFT;
   localparam logic [ZP_W-1:0] Z_ROUND = ZP_W'(1) << (dpb_pkg::Z_SHIFT - 1);

   dpb_pkg::dpb_cfg_type      cfg;
   dpb_pkg::dpb_stage_en_type en;

   logic [4:0]                     valid_ff, valid_in;
   logic [ZP_W-1:0]                zp_ff, zp_in;
   logic [ZP_W-1:0]                z_round;
   logic [ZS_W-1:0]                z_shift;
   logic [dpb_pkg::Z_BITS-1:0]     z2_ff, z2_in, z3_ff, z4_ff, z5_ff;
   dpb_pkg::dpb_color_type         c1_ff, c1_in, c2_ff, c3_ff, c4_ff, c5_ff;
   logic signed [dpb_pkg::POINT_BITS-1:0] point_x, point_y;

   // Configuration registers.
   dpb_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .cfg       (cfg)
   );

   // A stage loads when it is empty or the stage after it moves on.
   always_comb begin
      en.s5 = !valid_ff[4] || rsp_point.ready;
      en.s4 = !valid_ff[3] || en.s5;
      en.s3 = !valid_ff[2] || en.s4;
      en.s2 = !valid_ff[1] || en.s3;
      en.s1 = !valid_ff[0] || en.s2;
   end

   assign req_pixel.ready = en.s1;

   // Valid bits follow their data down the pipeline.
   always_comb begin
      valid_in = valid_ff;
      if (en.s1) valid_in[0] = req_pixel.valid;
      if (en.s2) valid_in[1] = valid_ff[0];
      if (en.s3) valid_in[2] = valid_ff[1];
      if (en.s4) valid_in[3] = valid_ff[2];
      if (en.s5) valid_in[4] = valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1 depth product; stage 2 rounds and saturates it to Q8.16.
   always_comb begin
      zp_in   = ZP_W'(req_pixel.depth) * ZP_W'(cfg.inv_depth_scale);
      c1_in.blue  = req_pixel.blue;
      c1_in.green = req_pixel.green;
      c1_in.red   = req_pixel.red;
      z_round = zp_ff + Z_ROUND;
      z_shift = z_round[ZP_W-1:dpb_pkg::Z_SHIFT];
      z2_in   = (z_shift[ZS_W-1:dpb_pkg::Z_BITS] != '0) ? '1 :
                z_shift[dpb_pkg::Z_BITS-1:0];
   end

   // Depth and colour travel with the lateral lanes.
   always_ff @(posedge clock) begin
      if (en.s1) begin
         zp_ff <= zp_in;
         c1_ff <= c1_in;
      end
      if (en.s2) begin
         z2_ff <= z2_in;
         c2_ff <= c1_ff;
      end
      if (en.s3) begin
         z3_ff <= z2_ff;
         c3_ff <= c2_ff;
      end
      if (en.s4) begin
         z4_ff <= z3_ff;
         c4_ff <= c3_ff;
      end
      if (en.s5) begin
         z5_ff <= z4_ff;
         c5_ff <= c4_ff;
      end
   end

   // Horizontal lane.
   dpb_axis_lane #(
      .COORD_BITS (COORD_BITS)
   ) u_lane_x (
      .clock  (clock),
      .en     (en),
      .coord  (req_pixel.column),
      .center (cfg.center_x_halves),
      .inv    (cfg.inv_focal_x),
      .z      (z2_ff),
      .point  (point_x)
   );

   // Vertical lane.
   dpb_axis_lane #(
      .COORD_BITS (COORD_BITS)
   ) u_lane_y (
      .clock  (clock),
      .en     (en),
      .coord  (req_pixel.row),
      .center (cfg.center_y_halves),
      .inv    (cfg.inv_focal_y),
      .z      (z2_ff),
      .point  (point_y)
   );

   // Response channel is driven straight from the last stage registers.
   assign rsp_point.valid     = valid_ff[4];
   assign rsp_point.point_x   = point_x;
   assign rsp_point.point_y   = point_y;
   assign rsp_point.point_z   = z5_ff;
   assign rsp_point.out_blue  = c5_ff.blue;
   assign rsp_point.out_green = c5_ff.green;
   assign rsp_point.out_red   = c5_ff.red;

endmodule

// File: tb/depth_pixel_backprojection_core_tb.sv
// Self-checking testbench: depth pixels in, 3-D points checked against a bit-exact predictor.
`timescale 1ns / 1ps

module depth_pixel_backprojection_core_tb;
   import dpb_pkg::*;

   localparam int COORD_BITS        = COORD_BITS_DEFAULT;
   localparam int COORD_MAX         = (1 << COORD_BITS) - 1;
   localparam int DEPTH_MAX         = (1 << DEPTH_BITS) - 1;
   localparam int CSR_INDEX_COUNT   = 1 << CSR_INDEX_BITS;
   localparam logic [Z_BITS-1:0]   Z_LIMIT = '1;
   localparam logic [INV_BITS-1:0] INV_MAX = 24'h7F_FFFF;
   localparam logic [INV_BITS-1:0] INV_MIN = 24'h80_0000;
   localparam int MAX_REPORTS       = 40;
   localparam int LONG_STALL_CYCLES = 400;
   localparam int DRAIN_CYCLES      = 20;
   localparam int TIMEOUT_NS        = 3_000_000;

   typedef struct packed {
      logic [COORD_BITS-1:0] column;
      logic [COORD_BITS-1:0] row;
      logic [DEPTH_BITS-1:0] depth;
      dpb_color_type         color;
   } depth_pixel_type;

   typedef struct packed {
      logic signed [POINT_BITS-1:0] point_x;
      logic signed [POINT_BITS-1:0] point_y;
      logic [Z_BITS-1:0]            point_z;
      dpb_color_type                color;
   } cloud_point_type;

   logic clock = 1'b0;
   logic reset;

   // Camera registers as the predictor sees them.
   dpb_cfg_type camera_cfg;

   // Requests waiting to be driven and points still owed by the block.
   depth_pixel_type pixel_queue[$];
   cloud_point_type points_due[$];

   int unsigned pixel_idle_pct   = 0;
   int unsigned point_idle_pct   = 0;
   int unsigned pixel_gap_left   = 0;
   int unsigned point_gap_left   = 0;
   logic        long_stall_go    = 1'b0;
   logic        receiver_stalled = 1'b0;
   int          mismatch_count   = 0;

   dpb_pixel_if #(.COORD_BITS(COORD_BITS)) pixel_bus ();
   dpb_point_if point_bus ();
   dpb_csr_if   csr_bus ();

   depth_pixel_backprojection_core #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_pixel (pixel_bus),
      .rsp_point (point_bus),
      .csr_write (csr_bus)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offset times depth times inverse focal length, rounded half away from zero
   // on the magnitude, then clamped to the signed 32-bit range.
   function automatic logic signed [POINT_BITS-1:0] project_offset(
      input int                          offset,
      input logic [Z_BITS-1:0]           z,
      input logic signed [INV_BITS-1:0]  inv
   );
      logic        negative;
      logic [63:0] mag_offset;
      logic [63:0] mag_inv;
      logic [63:0] mag;
      negative   = (offset < 0) != (inv < 0);
      mag_offset = (offset < 0) ? 64'(-offset) : 64'(offset);
      mag_inv    = (inv < 0) ? 64'(-longint'(inv)) : 64'(longint'(inv));
      mag        = mag_offset * 64'(z) * mag_inv;
      mag        = (mag + (64'd1 << (XY_SHIFT - 1))) >> XY_SHIFT;
      if (negative) begin
         if (mag > 64'h8000_0000) mag = 64'h8000_0000;
         return POINT_BITS'(64'd0 - mag);
      end
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return POINT_BITS'(mag);
   endfunction

   // Expected point for one pixel under the current camera registers.
   function automatic cloud_point_type backproject(input depth_pixel_type px);
      cloud_point_type   pt;
      logic [63:0]       z_wide;
      logic [Z_BITS-1:0] z;
      int                dx;
      int                dy;
      z_wide = (64'(px.depth) * 64'(camera_cfg.inv_depth_scale)
                + (64'd1 << (Z_SHIFT - 1))) >> Z_SHIFT;
      z  = (z_wide > 64'(Z_LIMIT)) ? Z_LIMIT : Z_BITS'(z_wide);
      dx = 2 * int'(px.column) - int'(camera_cfg.center_x_halves);
      dy = 2 * int'(px.row) - int'(camera_cfg.center_y_halves);
      pt.point_x = project_offset(dx, z, camera_cfg.inv_focal_x);
      pt.point_y = project_offset(dy, z, camera_cfg.inv_focal_y);
      pt.point_z = z;
      pt.color   = px.color;
      return pt;
   endfunction

   task automatic report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   // Track register writes; unmapped indexes and bits above each width are dropped.
   always @(posedge clock) begin : register_tracker
      if (reset) begin
         camera_cfg <= '{INV_DEPTH_SCALE_RESET, CENTER_X_RESET, CENTER_Y_RESET,
                         INV_FOCAL_X_RESET, INV_FOCAL_Y_RESET};
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            REG_INV_DEPTH_SCALE: camera_cfg.inv_depth_scale <= csr_bus.data;
            REG_CENTER_X:        camera_cfg.center_x_halves <= csr_bus.data[CENTER_BITS-1:0];
            REG_CENTER_Y:        camera_cfg.center_y_halves <= csr_bus.data[CENTER_BITS-1:0];
            REG_INV_FOCAL_X:     camera_cfg.inv_focal_x     <= csr_bus.data[INV_BITS-1:0];
            REG_INV_FOCAL_Y:     camera_cfg.inv_focal_y     <= csr_bus.data[INV_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Request driver: predicts each accepted pixel and offers the next one,
   // with random idle bursts between requests.
   always @(posedge clock) begin : pixel_driver
      depth_pixel_type seen_pixel;
      depth_pixel_type next_pixel;
      logic            offer;
      if (reset) begin
         pixel_bus.valid <= 1'b0;
         pixel_gap_left  <= 0;
      end else begin
         if (pixel_bus.valid && pixel_bus.ready) begin
            seen_pixel.column = pixel_bus.column;
            seen_pixel.row    = pixel_bus.row;
            seen_pixel.depth  = pixel_bus.depth;
            seen_pixel.color  = '{pixel_bus.blue, pixel_bus.green, pixel_bus.red};
            points_due.insert(points_due.size(), backproject(seen_pixel));
         end
         if (!pixel_bus.valid || pixel_bus.ready) begin
            offer = 1'b0;
            if (pixel_gap_left != 0) begin
               pixel_gap_left <= pixel_gap_left - 1;
            end else if (pixel_queue.size() != 0) begin
               if ($urandom_range(99) < pixel_idle_pct) begin
                  // This cycle starts a random idle burst.
                  pixel_gap_left <= $urandom_range(13);
               end else begin
                  next_pixel = pixel_queue.pop_front();
                  offer      = 1'b1;
                  pixel_bus.column <= next_pixel.column;
                  pixel_bus.row    <= next_pixel.row;
                  pixel_bus.depth  <= next_pixel.depth;
                  pixel_bus.blue   <= next_pixel.color.blue;
                  pixel_bus.green  <= next_pixel.color.green;
                  pixel_bus.red    <= next_pixel.color.red;
               end
            end
            pixel_bus.valid <= offer;
         end
      end
   end

   // Response monitor: compares each point with the oldest prediction and
   // drives ready with random stall bursts and the long hold-off.
   always @(posedge clock) begin : point_receiver
      cloud_point_type want;
      logic            take;
      if (reset) begin
         point_bus.ready <= 1'b0;
         point_gap_left  <= 0;
      end else begin
         if (point_bus.valid && point_bus.ready) begin
            if (points_due.size() == 0) begin
               report_error("point returned with no request outstanding");
            end else begin
               want = points_due.pop_front();
               if (point_bus.point_x !== want.point_x)
                  report_error($sformatf("point_x: got %0d, expected %0d",
                                         point_bus.point_x, want.point_x));
               if (point_bus.point_y !== want.point_y)
                  report_error($sformatf("point_y: got %0d, expected %0d",
                                         point_bus.point_y, want.point_y));
               if (point_bus.point_z !== want.point_z)
                  report_error($sformatf("point_z: got %0d, expected %0d",
                                         point_bus.point_z, want.point_z));
               if (point_bus.out_blue !== want.color.blue)
                  report_error($sformatf("out_blue: got %0d, expected %0d",
                                         point_bus.out_blue, want.color.blue));
               if (point_bus.out_green !== want.color.green)
                  report_error($sformatf("out_green: got %0d, expected %0d",
                                         point_bus.out_green, want.color.green));
               if (point_bus.out_red !== want.color.red)
                  report_error($sformatf("out_red: got %0d, expected %0d",
                                         point_bus.out_red, want.color.red));
            end
         end
         take = 1'b1;
         if (receiver_stalled) begin
            take = 1'b0;
         end else if (point_gap_left != 0) begin
            take           = 1'b0;
            point_gap_left <= point_gap_left - 1;
         end else if ($urandom_range(99) < point_idle_pct) begin
            take           = 1'b0;
            point_gap_left <= $urandom_range(13);
         end
         point_bus.ready <= take;
      end
   end

   // One long receiver hold-off so the pipeline fills and back-pressures requests.
   initial begin : long_stall
      wait (long_stall_go);
      repeat (30) @(posedge clock);
      receiver_stalled <= 1'b1;
      repeat (LONG_STALL_CYCLES) @(posedge clock);
      receiver_stalled <= 1'b0;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("depth_pixel_backprojection_core_tb: done, errors");
      $finish;
   end

   task automatic write_register(
      input logic [CSR_INDEX_BITS-1:0] reg_index,
      input logic [CSR_DATA_BITS-1:0]  value
   );
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= reg_index;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // Write all five camera registers; with dirty set the unused upper bits carry noise.
   task automatic load_camera(
      input logic [SCALE_BITS-1:0]  scale,
      input logic [CENTER_BITS-1:0] cx,
      input logic [CENTER_BITS-1:0] cy,
      input logic [INV_BITS-1:0]    fx,
      input logic [INV_BITS-1:0]    fy,
      input logic                   dirty
   );
      logic [CSR_DATA_BITS-1:0] junk;
      junk = dirty ? $urandom : '0;
      write_register(REG_INV_DEPTH_SCALE, scale);
      write_register(REG_CENTER_X, {junk[CSR_DATA_BITS-1:CENTER_BITS], cx});
      write_register(REG_CENTER_Y, {~junk[CSR_DATA_BITS-1:CENTER_BITS], cy});
      write_register(REG_INV_FOCAL_X, {junk[CSR_DATA_BITS-1:INV_BITS], fx});
      write_register(REG_INV_FOCAL_Y, {~junk[CSR_DATA_BITS-1:INV_BITS], fy});
   endtask

   task automatic load_random_camera();
      logic [SCALE_BITS-1:0] scale;
      logic [INV_BITS-1:0]   fx;
      logic [INV_BITS-1:0]   fy;
      case ($urandom_range(3))
         0:       scale = $urandom;
         1:       scale = $urandom_range(1 << 22);
         2:       scale = 32'hFFFF_FFFF - $urandom_range(1 << 26);
         default: scale = INV_DEPTH_SCALE_RESET;
      endcase
      fx = $urandom_range(1) ? INV_BITS'($urandom)
                             : INV_BITS'(int'($urandom_range(200000)) - 100000);
      fy = $urandom_range(1) ? INV_BITS'($urandom)
                             : INV_BITS'(int'($urandom_range(200000)) - 100000);
      load_camera(scale, CENTER_BITS'($urandom), CENTER_BITS'($urandom), fx, fy, 1'b1);
   endtask

   // Phases begin on a falling edge so queue updates never race the driver.
   task automatic start_phase(input int unsigned sender_pct, input int unsigned receiver_pct);
      @(negedge clock);
      pixel_idle_pct = sender_pct;
      point_idle_pct = receiver_pct;
   endtask

   function automatic int unsigned pick_idle_pct();
      return ($urandom_range(2) == 0) ? 0 : $urandom_range(50);
   endfunction

   function automatic void queue_pixel(
      input int                  col,
      input int                  row,
      input int                  depth,
      input logic [3*COLOR_BITS-1:0] bgr
   );
      depth_pixel_type px;
      px.column = COORD_BITS'(col);
      px.row    = COORD_BITS'(row);
      px.depth  = DEPTH_BITS'(depth);
      px.color  = dpb_color_type'(bgr);
      pixel_queue.insert(pixel_queue.size(), px);
   endfunction

   // Random pixels, weighted toward image edges and toward zero, tiny and full depth.
   function automatic void queue_random_pixels(input int count);
      int col;
      int row;
      int depth;
      repeat (count) begin
         col = ($urandom_range(7) == 0) ? COORD_MAX * $urandom_range(1) : $urandom_range(COORD_MAX);
         row = ($urandom_range(7) == 0) ? COORD_MAX * $urandom_range(1) : $urandom_range(COORD_MAX);
         case ($urandom_range(9))
            0:       depth = 0;
            1:       depth = DEPTH_MAX;
            2, 3, 4: depth = $urandom_range(255);
            default: depth = $urandom_range(DEPTH_MAX);
         endcase
         queue_pixel(col, row, depth, 24'($urandom));
      end
   endfunction

   // Wait until every queued request has been sent and has come back as a point.
   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_queue.size() != 0 || points_due.size() != 0 || pixel_bus.valid);
   endtask

   initial begin : sequencer
      int idx;
      reset            = 1'b1;
      pixel_bus.valid  = 1'b0;
      pixel_bus.column = '0;
      pixel_bus.row    = '0;
      pixel_bus.depth  = '0;
      pixel_bus.blue   = '0;
      pixel_bus.green  = '0;
      pixel_bus.red    = '0;
      point_bus.ready  = 1'b0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels under the reset camera: corners, center, tiny and full depth.
      start_phase(20, 20);
      queue_pixel(0, 0, 0, 24'h000000);
      queue_pixel(COORD_MAX, COORD_MAX, DEPTH_MAX, 24'hFFFFFF);
      queue_pixel(319, 239, 5000, 24'h123456);
      queue_pixel(320, 240, 5000, 24'h654321);
      queue_pixel(0, COORD_MAX, 1, 24'hAA55AA);
      queue_pixel(COORD_MAX, 0, 1, 24'h55AA55);
      queue_pixel(640, 480, DEPTH_MAX, 24'h0F0F0F);
      queue_pixel(1, 1, 32768, 24'hF0F0F0);
      queue_pixel(2048, 2048, 12345, 24'h807F01);
      queue_pixel(COORD_MAX - 1, 2, 40000, 24'h01FE80);
      wait_drained();

      // Full scale: depth saturates, x clamps high and y clamps low.
      load_camera(32'hFFFF_FFFF, '0, '0, INV_MAX, INV_MIN, 1'b0);
      start_phase(10, 30);
      queue_pixel(COORD_MAX, COORD_MAX, DEPTH_MAX, 24'hFF00FF);
      queue_pixel(0, 0, DEPTH_MAX, 24'h00FF00);
      queue_pixel(1, 1, 255, 24'h112233);
      queue_pixel(1, 1, 256, 24'h445566);
      queue_pixel(1, 1, 257, 24'h778899);
      queue_random_pixels(60);
      wait_drained();

      // Centers at the far corner: x clamps low and y clamps high.
      load_camera(32'hFFFF_FFFF, '1, '1, INV_MAX, INV_MIN, 1'b0);
      start_phase(0, 0);
      queue_pixel(0, 0, DEPTH_MAX, 24'hABCDEF);
      queue_pixel(COORD_MAX, COORD_MAX, DEPTH_MAX, 24'hFEDCBA);
      queue_random_pixels(60);
      wait_drained();

      // Exact half-way rounding in both signs.
      load_camera(32'h0001_0000, 13'd1, 13'd1, INV_MIN, 24'h40_0000, 1'b0);
      start_phase(30, 10);
      queue_pixel(1, 1, 2, 24'h010203);
      queue_pixel(1, 1, 4, 24'h040506);
      queue_pixel(0, 0, 2, 24'h070809);
      queue_pixel(0, 0, 4, 24'h0A0B0C);
      queue_pixel(1, 0, 6, 24'h0D0E0F);
      queue_pixel(0, 1, 6, 24'h101112);
      queue_random_pixels(20);
      wait_drained();

      // Zero scale and zero horizontal focal term: every coordinate is zero.
      load_camera('0, 13'd4096, 13'd4095, '0, INV_MAX, 1'b0);
      start_phase(15, 15);
      queue_pixel(COORD_MAX, COORD_MAX, DEPTH_MAX, 24'h3C3C3C);
      queue_pixel(0, 0, DEPTH_MAX, 24'hC3C3C3);
      queue_random_pixels(20);
      wait_drained();

      // Writes to unmapped indexes must not disturb the camera registers.
      load_random_camera();
      for (idx = int'(REG_INV_FOCAL_Y) + 1; idx < CSR_INDEX_COUNT; idx++)
         write_register(CSR_INDEX_BITS'(idx), $urandom);
      start_phase(pick_idle_pct(), pick_idle_pct());
      queue_random_pixels(100);
      wait_drained();

      // Random cameras with random idle on both sides.
      repeat (5) begin
         load_random_camera();
         start_phase(pick_idle_pct(), pick_idle_pct());
         queue_random_pixels(100);
         wait_drained();
      end

      // Long receiver hold-off while the sender keeps requesting.
      load_random_camera();
      start_phase(0, 10);
      long_stall_go = 1'b1;
      queue_random_pixels(120);
      wait_drained();

      // Closing stretch at full rate.
      load_random_camera();
      start_phase(0, 0);
      queue_random_pixels(60);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("depth_pixel_backprojection_core_tb: done, clean");
      end else begin
         $display("depth_pixel_backprojection_core_tb: done, errors");
      end
      $finish;
   end

endmodule
